### rtl/arl_pkg.sv
// arl_pkg: shared constants, request/result types and controller/datapath
// interface types for the address range lookup block. No dependencies.
package arl_pkg;

  localparam int unsigned ENTRIES = 128;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SLOT_W  = 7;
  localparam int unsigned ADDR_W  = 64;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_LOOKUP = 2'd2
  } arl_mode_e;

  typedef struct packed {
    arl_mode_e           mode;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   region_base;
    logic [ADDR_W-1:0]   region_size;
    logic [ADDR_W-1:0]   address;
  } arl_req_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   entry_index;
    logic [ADDR_W-1:0]   offset;
  } arl_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_END,
    ST_RESP
  } arl_state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // write slot from request
    logic clear;      // drop all valid marks
    logic ack_zero;   // all-zero result
    logic scan_init;  // latch address, reset scan
    logic scan_step;  // issue one table read
    logic calc_end;   // form end of chosen region
    logic finish;     // form lookup result
  } arl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic scan_last;  // read of the last slot is being issued
  } arl_stat_t;

endpackage

### rtl/arl_ctrl.sv
// arl_ctrl: sequencing state machine for the address range lookup.
// Depends on arl_pkg.
module arl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  arl_pkg::arl_mode_e  mode_i,
  input  arl_pkg::arl_stat_t  stat_i,
  output logic                busy,
  output arl_pkg::arl_cmd_t   cmd_o
);
  import arl_pkg::*;

  arl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (mode_i)
            MODE_LOOKUP: begin
              cmd_o.scan_init = 1'b1;
              state_d         = ST_SCAN;
            end
            MODE_LOAD: begin
              cmd_o.load     = 1'b1;
              cmd_o.ack_zero = 1'b1;
            end
            MODE_CLEAR: begin
              cmd_o.clear    = 1'b1;
              cmd_o.ack_zero = 1'b1;
            end
            default: begin
              cmd_o.ack_zero = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      // last read data is compared here
      ST_DRAIN: begin
        state_d = ST_END;
      end
      ST_END: begin
        cmd_o.calc_end = 1'b1;
        state_d        = ST_RESP;
      end
      ST_RESP: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

### rtl/arl_datapath.sv
// arl_datapath: region table memories, valid marks, scan compare and result
// register for the address range lookup. Depends on arl_pkg.
module arl_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arl_pkg::arl_req_t  req_i,
  input  arl_pkg::arl_cmd_t  cmd_i,
  output arl_pkg::arl_stat_t stat_o,
  output logic               strobe_o,
  output arl_pkg::arl_rsp_t  rsp_o
);
  import arl_pkg::*;

  localparam int unsigned EXT_W = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
  localparam int unsigned CMP_W = EXT_W + 1;

  // table
  logic [ADDR_W-1:0] base_mem [ENTRIES];
  logic [ADDR_W-1:0] size_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;

  logic [CMP_W-1:0]  slot_ext;
  logic              slot_ok;
  logic [IDX_W-1:0]  wr_idx;

  // scan
  logic [ADDR_W-1:0] addr_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              rd_ok_q;
  logic [IDX_W-1:0]  idx_rd_q;
  logic              vld_rd_q;
  logic [ADDR_W-1:0] base_rd_q, size_rd_q;

  // best candidate
  logic              found_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [ADDR_W-1:0] best_base_q, best_size_q;
  logic              cand;

  logic [ADDR_W:0]   sum;
  logic [ADDR_W-1:0] end_q;
  logic              hit;

  logic              strobe_q;
  arl_rsp_t          rsp_q;

  assign slot_ext = CMP_W'(req_i.slot);
  assign slot_ok  = slot_ext < CMP_W'(ENTRIES);
  assign wr_idx   = IDX_W'(slot_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && slot_ok) begin
      base_mem[wr_idx] <= req_i.region_base;
      size_mem[wr_idx] <= req_i.region_size;
    end
    base_rd_q <= base_mem[rd_idx_q];
    size_rd_q <= size_mem[rd_idx_q];
    idx_rd_q  <= rd_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_ok_q  <= 1'b0;
      vld_rd_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else if (cmd_i.load && slot_ok) begin
        valid_q[wr_idx] <= 1'b1;
      end
      rd_ok_q  <= cmd_i.scan_step;
      vld_rd_q <= valid_q[rd_idx_q];
      if (cmd_i.scan_init) begin
        rd_idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
    end
  end

  assign stat_o.scan_last = (rd_idx_q == IDX_W'(ENTRIES - 1));

  // strict greater keeps the lowest slot among equal bases
  assign cand = rd_ok_q && vld_rd_q && (base_rd_q <= addr_q) &&
                (!found_q || (base_rd_q > best_base_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      found_q <= 1'b0;
    end else if (cand) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      addr_q <= req_i.address;
    end
    if (cand) begin
      best_idx_q  <= idx_rd_q;
      best_base_q <= base_rd_q;
      best_size_q <= size_rd_q;
    end
    if (cmd_i.calc_end) begin
      // wrap or zero size: region runs to the top of the space
      end_q <= (sum[ADDR_W] || (best_size_q == '0)) ? '1 : sum[ADDR_W-1:0];
    end
  end

  assign sum = {1'b0, best_base_q} + {1'b0, best_size_q};
  // base <= address is guaranteed by the scan
  assign hit = found_q && (addr_q != '0) && (addr_q < end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.finish || cmd_i.ack_zero;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ack_zero) begin
      rsp_q <= '0;
    end else if (cmd_i.finish) begin
      rsp_q.hit         <= hit;
      rsp_q.entry_index <= hit ? SLOT_W'(best_idx_q) : '0;
      rsp_q.offset      <= hit ? (addr_q - best_base_q) : '0;
    end
  end

  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;

endmodule

### rtl/address_range_lookup.sv
// address_range_lookup: top level, controller plus datapath.
// Depends on arl_pkg, arl_ctrl, arl_datapath.
//
// Region table of ENTRIES (128) slots, each a 64-bit base and size with a
// valid mark. A request is taken when start is high and busy is low; its
// one result appears on rsp_o for a single cycle with strobe_o high, and the
// receiver cannot stall it. Load (write one slot; slots past the table are
// ignored), clear (drop every valid mark) and the unused mode answer with an
// all-zero result in the cycle after acceptance, and busy stays low, so such
// requests may be issued every cycle. A lookup raises busy until its result
// is formed, and the result comes with strobe_o as busy falls: the scan reads
// the table through one read port, one slot per cycle, then the DRAIN, END
// and RESP states make the last compare, form the region end and form the
// result. Among valid slots the greatest base not above the address wins,
// the lowest slot on equal bases; it hits when the address is non-zero and
// below base plus size, where a sum that wraps or a zero size reaches the
// top of the address space. No clearing pass is run after reset; the valid
// marks clear at once.
module address_range_lookup (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  arl_pkg::arl_req_t req_i,
  output logic              busy,
  output logic              strobe_o,
  output arl_pkg::arl_rsp_t rsp_o
);
  import arl_pkg::*;

  arl_cmd_t  cmd;
  arl_stat_t stat;

  arl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (req_i.mode),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  arl_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .strobe_o (strobe_o),
    .rsp_o    (rsp_o)
  );

  // A taken request either starts a lookup or answers next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || strobe_o))
    else $error("accepted request neither busy nor answered");

  // Leaving a lookup always delivers its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> strobe_o)
    else $error("lookup finished without result");

  // A miss reports zero slot and offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !rsp_o.hit) |-> (rsp_o.entry_index == '0 && rsp_o.offset == '0))
    else $error("miss with non-zero fields");

  // A lookup result never arrives while another lookup runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |-> !strobe_o)
    else $error("result strobe during scan");

endmodule

### test/tb.sv
// tb: self-checking testbench for address_range_lookup (region table lookup).
// Depends on arl_pkg and the address_range_lookup RTL; directed table first,
// then weighted random requests checked against an in-bench region model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arl_pkg::*;

  // Mode 3 is not an enum member; the block must treat it as a no-op.
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [63:0] ADDR_TOP    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int unsigned RANDOM_REQS = 450;
  // A lookup holds busy until its result is formed; the result strobes as busy falls.
  localparam int unsigned TAIL_CYCLES = ENTRIES + 8;

  typedef struct {
    arl_req_t req;
    bit       pinned;  // expected result typed in below, not predicted
    arl_rsp_t rsp;
  } plan_row_t;

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     start_q   = 1'b0;
  arl_req_t req_q     = '0;
  bit       pin_q     = 1'b0;
  arl_rsp_t pin_rsp_q = '0;
  logic     busy;
  logic     strobe_o;
  arl_rsp_t rsp_o;

  address_range_lookup dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start_q),
    .req_i    (req_q),
    .busy     (busy),
    .strobe_o (strobe_o),
    .rsp_o    (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Region model: our own copy of the table, updated as requests are taken.
  // ---------------------------------------------------------------------
  logic [63:0] region_base_m [ENTRIES];
  logic [63:0] region_size_m [ENTRIES];
  bit          region_valid_m[ENTRIES];

  arl_rsp_t  expected_rsp[$];
  plan_row_t plan[$];

  int unsigned errors = 0;
  int unsigned n_load = 0, n_clear = 0, n_lookup = 0, n_hit = 0, n_unused = 0;

  // Applies one request to the model table and returns the result it should
  // produce. Lookup: greatest valid base not above the address, lowest slot
  // on a tie (strict > keeps the first one met), then an exclusive end test
  // where a wrapping sum or a zero size stretches the end to the top.
  function automatic arl_rsp_t resolve_request(arl_req_t r);
    arl_rsp_t    rsp;
    bit          found;
    int unsigned pick;
    int unsigned i;
    logic [64:0] span;
    logic [63:0] region_end;
    rsp   = '0;
    found = 1'b0;
    pick  = 0;
    case (r.mode)
      MODE_LOAD: begin
        if (32'(r.slot) < ENTRIES) begin
          region_base_m[r.slot]  = r.region_base;
          region_size_m[r.slot]  = r.region_size;
          region_valid_m[r.slot] = 1'b1;
        end
      end
      MODE_CLEAR: begin
        for (i = 0; i < ENTRIES; i++) region_valid_m[i] = 1'b0;
      end
      MODE_LOOKUP: begin
        if (r.address != '0) begin
          for (i = 0; i < ENTRIES; i++) begin
            if (region_valid_m[i] && region_base_m[i] <= r.address &&
                (!found || region_base_m[i] > region_base_m[pick])) begin
              found = 1'b1;
              pick  = i;
            end
          end
          if (found) begin
            span       = {1'b0, region_base_m[pick]} + {1'b0, region_size_m[pick]};
            region_end = (span[64] || region_size_m[pick] == '0) ? ADDR_TOP : span[63:0];
            if (r.address < region_end) begin
              rsp.hit         = 1'b1;
              rsp.entry_index = pick[SLOT_W-1:0];
              rsp.offset      = r.address - region_base_m[pick];
            end
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: checks strobed results in order, then records the request
  // taken at this edge. All values read here are the pre-edge ones.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    arl_rsp_t want;
    arl_rsp_t model_rsp;
    if (rst_ni) begin
      if (strobe_o) begin
        if (expected_rsp.size() == 0) begin
          errors++;
          $display("%0t: unexpected result hit=%0b entry=%0d offset=%h",
                   $time, rsp_o.hit, rsp_o.entry_index, rsp_o.offset);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_o.hit !== want.hit) begin
            errors++;
            $display("%0t: hit mismatch, expected %0b got %0b",
                     $time, want.hit, rsp_o.hit);
          end
          if (rsp_o.entry_index !== want.entry_index) begin
            errors++;
            $display("%0t: entry_index mismatch, expected %0d got %0d",
                     $time, want.entry_index, rsp_o.entry_index);
          end
          if (rsp_o.offset !== want.offset) begin
            errors++;
            $display("%0t: offset mismatch, expected %h got %h",
                     $time, want.offset, rsp_o.offset);
          end
        end
      end
      if (start_q && !busy) begin
        model_rsp    = resolve_request(req_q);
        expected_rsp = {expected_rsp, (pin_q ? pin_rsp_q : model_rsp)};
        case (req_q.mode)
          MODE_LOAD:   n_load++;
          MODE_CLEAR:  n_clear++;
          MODE_LOOKUP: begin
            n_lookup++;
            if (model_rsp.hit) n_hit++;
          end
          default:     n_unused++;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random valid slot of the model table, or -1 if the table is empty.
  function automatic int valid_slot();
    int          live[$];
    int unsigned i;
    for (i = 0; i < ENTRIES; i++) if (region_valid_m[i]) live = {live, int'(i)};
    if (live.size() == 0) return -1;
    return live[$urandom_range(0, live.size() - 1)];
  endfunction

  task automatic add_row(input logic [1:0] mode, input logic [6:0] slot,
                         input logic [63:0] base, input logic [63:0] size,
                         input logic [63:0] addr, input bit pinned,
                         input arl_rsp_t want);
    plan_row_t row;
    row.req.mode        = arl_mode_e'(mode);
    row.req.slot        = slot;
    row.req.region_base = base;
    row.req.region_size = size;
    row.req.address     = addr;
    row.pinned          = pinned;
    row.rsp             = want;
    plan                = {plan, row};
  endtask

  // Presents one request after an idle gap and returns at the edge that
  // takes it. With no gap start stays high, so back-to-back loads stream.
  task automatic send_request(input arl_req_t r, input bit pinned,
                              input arl_rsp_t want, input int unsigned gap);
    if (gap > 0) begin
      start_q <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_q     <= r;
    pin_q     <= pinned;
    pin_rsp_q <= want;
    start_q   <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // Weighted random request. Loads favour bases that tie, neighbour or sit
  // near the top; lookups mostly aim at the edges of live regions so that
  // hits and just-missed ends both turn up. Unused fields carry noise.
  function automatic arl_req_t random_request();
    arl_req_t    r;
    int unsigned pick;
    int          s;
    logic [63:0] b;
    logic [63:0] sz;
    r.mode        = MODE_LOOKUP;
    r.slot        = 7'($urandom_range(0, 127));
    r.region_base = rand64();
    r.region_size = rand64();
    r.address     = rand64();
    pick          = $urandom_range(0, 99);
    if (pick < 2) begin
      r.mode = MODE_CLEAR;
    end else if (pick < 5) begin
      r.mode = arl_mode_e'(MODE_UNUSED);
    end else if (pick < 50) begin
      r.mode = MODE_LOAD;
      if ($urandom_range(0, 1)) r.slot = 7'($urandom_range(0, 15));
      s = valid_slot();
      case ($urandom_range(0, 5))
        0: b = rand64();
        1: b = (s < 0) ? rand64() : region_base_m[s];                       // tie
        2: b = (s < 0) ? rand64() : region_base_m[s] + 64'($urandom_range(1, 4096));
        3: b = {32'h0, $urandom};
        4: b = ADDR_TOP - 64'($urandom_range(0, 65535));
        default: b = 64'h0000_7FFF_0000_0000 + 64'($urandom_range(0, 65535)) * 64'd16;
      endcase
      case ($urandom_range(0, 4))
        0: sz = '0;
        1: sz = 64'($urandom_range(1, 256));
        2: sz = 64'($urandom_range(1, 1 << 20));
        3: sz = rand64();
        default: sz = ADDR_TOP - b + 64'($urandom_range(0, 2));   // around the top
      endcase
      r.region_base = b;
      r.region_size = sz;
    end else begin
      s = valid_slot();
      case ($urandom_range(0, 9))
        0: r.address = '0;
        1: r.address = ADDR_TOP;
        2: r.address = rand64();
        default: begin
          if (s >= 0) begin
            b  = region_base_m[s];
            sz = region_size_m[s];
            case ($urandom_range(0, 5))
              0: r.address = b;
              1: r.address = b + sz - 64'd1;
              2: r.address = b + sz;
              3: r.address = b + sz + 64'd1;
              4: r.address = b - 64'd1;
              default: r.address = b + (sz == '0 ? rand64() : rand64() % sz);
            endcase
          end
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main
    arl_rsp_t    hit_rsp;
    bit          burst;
    int unsigned n;
    int unsigned k;
    for (k = 0; k < ENTRIES; k++) begin
      region_valid_m[k] = 1'b0;
      region_base_m[k]  = '0;
      region_size_m[k]  = '0;
    end

    // Directed table: table extremes, every mode and each corner of the
    // lookup rule. Pinned rows carry an obvious result.
    hit_rsp = '{hit: 1'b1, entry_index: 7'd0, offset: 64'h10};
    add_row(MODE_LOOKUP, 7'd0, '0, '0, 64'h1, 1'b1, '0);         // empty table
    add_row(MODE_LOOKUP, 7'd0, '0, '0, ADDR_TOP, 1'b1, '0);
    add_row(MODE_LOAD, 7'd0, '0, 64'h100, '0, 1'b1, '0);
    add_row(MODE_LOOKUP, 7'd0, '0, '0, '0, 1'b1, '0);            // address zero
    add_row(MODE_LOOKUP, 7'd0, '0, '0, 64'h10, 1'b1, hit_rsp);
    add_row(MODE_LOAD, 7'd127, 64'h1000, '0, '0, 1'b1, '0);      // zero size
    add_row(MODE_LOOKUP, 7'd0, '0, '0, ADDR_TOP, 1'b1, '0);      // end exclusive
    add_row(MODE_LOOKUP, 7'd0, '0, '0, ADDR_TOP - 1, 1'b0, '0);
    add_row(MODE_LOAD, 7'd5, 64'h1000, 64'h10, '0, 1'b1, '0);    // equal base
    add_row(MODE_LOOKUP, 7'd0, '0, '0, 64'h1008, 1'b0, '0);
    add_row(MODE_LOOKUP, 7'd0, '0, '0, 64'h2000, 1'b0, '0);
    add_row(MODE_LOAD, 7'd64, 64'hFFFF_FFFF_FFFF_F000, ADDR_TOP, '0, 1'b1, '0);
    add_row(MODE_LOOKUP, 7'd0, '0, '0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '0);
    add_row(MODE_LOOKUP, 7'd0, '0, '0, 64'h0FFF, 1'b0, '0);
    add_row(MODE_UNUSED, 7'h7F, ADDR_TOP, ADDR_TOP, ADDR_TOP, 1'b1, '0);
    add_row(MODE_LOOKUP, 7'd0, '0, '0, 64'h100F, 1'b0, '0);
    add_row(MODE_CLEAR, 7'h7F, ADDR_TOP, ADDR_TOP, ADDR_TOP, 1'b1, '0);
    add_row(MODE_LOOKUP, 7'd0, '0, '0, 64'h1008, 1'b1, '0);      // all cleared
    add_row(MODE_LOAD, 7'd1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
            '0, 1'b1, '0);                                        // sum wraps to 0
    add_row(MODE_LOOKUP, 7'd0, '0, '0, ADDR_TOP - 1, 1'b0, '0);
    add_row(MODE_LOAD, 7'd2, ADDR_TOP, ADDR_TOP, '0, 1'b1, '0);
    add_row(MODE_LOOKUP, 7'd0, '0, '0, ADDR_TOP, 1'b1, '0);
    add_row(MODE_LOAD, 7'd0, 64'h1, 64'h1, '0, 1'b1, '0);
    add_row(MODE_LOOKUP, 7'd0, '0, '0, 64'h1, 1'b0, '0);
    add_row(MODE_CLEAR, 7'd0, '0, '0, '0, 1'b1, '0);

    // Reset held low from the start, released once.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_request(plan[i].req, plan[i].pinned, plan[i].rsp,
                                   $urandom_range(0, 9));

    // Random part: stretches of back-to-back requests between idling ones.
    burst = 1'b0;
    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      send_request(random_request(), 1'b0, '0, burst ? 0 : $urandom_range(0, 9));
    end
    start_q <= 1'b0;

    // Drain, bounded, then watch for stray strobes for a lookup's worth.
    k = 0;
    while (expected_rsp.size() != 0 && k < 4 * TAIL_CYCLES) begin
      @(posedge clk_i);
      k++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_rsp.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_rsp.size());
    end

    $display("Requests taken: %0d loads, %0d clears, %0d unused-mode, %0d lookups",
             n_load, n_clear, n_unused, n_lookup);
    $display("Lookups that hit: %0d, misses: %0d, mismatches: %0d",
             n_hit, n_lookup - n_hit, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a millisecond.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

### files.f
rtl/arl_pkg.sv
rtl/arl_ctrl.sv
rtl/arl_datapath.sv
rtl/address_range_lookup.sv
test/tb.sv
